@@ rtl/core/wrpp_pkg.sv @@
// Shared types and codes for the weighted-runtime process picker.
// No dependencies; used by wrpp_ctrl, wrpp_dpath and the top level.
package wrpp_pkg;

  // Request command codes.
  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_SET_STATE = 3'd1,
    CMD_SET_PRIO  = 3'd2,
    CMD_PICK      = 3'd3,
    CMD_READ      = 3'd4
  } cmd_code_t;

  // Process slot state codes.
  typedef enum logic [2:0] {
    PS_UNUSED   = 3'd0,
    PS_EMBRYO   = 3'd1,
    PS_SLEEPING = 3'd2,
    PS_RUNNABLE = 3'd3,
    PS_RUNNING  = 3'd4,
    PS_ZOMBIE   = 3'd5
  } proc_state_t;

  localparam logic [31:0] CNT_MAX     = 32'hFFFF_FFFF;
  localparam logic [3:0]  DEF_PRIO_RST = 4'd2;

  // One row of the slot table.
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  weight;
    logic [31:0] sleep_cnt;
    logic [31:0] ready_cnt;
    logic [31:0] run_cnt;
  } row_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DRAIN1,
    S_DRAIN2,
    S_PSEL,
    S_RD,
    S_WR,
    S_DONE
  } ctl_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic clear_step;
    logic scan_step;
    logic rmw_rd;
    logic rmw_wr;
    logic out_load;
  } ctl_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic idx_last;
    logic is_scan;
    logic is_pick;
    logic is_rmw;
    logic have;
  } dp_status_t;

endpackage

@@ rtl/core/wrpp_ctrl.sv @@
// Controller state machine of the weighted-runtime process picker.
// Depends on wrpp_pkg; drives wrpp_dpath through command and status structs.
module wrpp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output wrpp_pkg::ctl_cmd_t  cmd,
  input  wrpp_pkg::dp_status_t st
);
  import wrpp_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.idx_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.is_scan)     state_nxt = S_SCAN;
        else if (st.is_rmw) state_nxt = S_RD;
        else                state_nxt = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.idx_last) state_nxt = S_DRAIN1;
      end
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_PSEL;
      S_PSEL: begin
        state_nxt = (st.is_pick && st.have) ? S_RD : S_DONE;
      end
      S_RD: begin
        cmd.rmw_rd = 1'b1;
        state_nxt  = S_WR;
      end
      S_WR: begin
        cmd.rmw_wr = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The output register holds a result until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load)              out_valid_nxt = 1'b1;
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/wrpp_dpath.sv @@
// Datapath of the weighted-runtime process picker: slot table memory,
// scan pipeline, cost compare and result registers. Depends on wrpp_pkg.
module wrpp_dpath #(
  parameter int SLOTS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wrpp_pkg::ctl_cmd_t   cmd,
  output wrpp_pkg::dp_status_t st,
  input  logic [2:0]           in_command,
  input  logic [5:0]           in_slot,
  input  logic [2:0]           in_new_state,
  input  logic [3:0]           in_new_priority,
  input  logic                 cfg_wr_en,
  input  logic [3:0]           cfg_wr_data,
  output logic                 out_found,
  output logic [5:0]           out_chosen_slot,
  output logic [3:0]           out_old_priority,
  output logic [31:0]          out_sleep_ticks,
  output logic [31:0]          out_ready_ticks,
  output logic [31:0]          out_run_ticks
);
  import wrpp_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int RW = $bits(row_t);

  // Slot table memory.
  logic [RW-1:0] mem [SLOTS];
  logic [RW-1:0] rd_data_r;
  logic          mem_re, mem_we;
  logic [IW-1:0] rd_addr, wr_addr;
  row_t          rd_row, wr_row;

  // Request and configuration registers.
  logic [2:0]    cmd_r;
  logic [5:0]    slot_r;
  logic [2:0]    nst_r;
  logic [3:0]    npri_r;
  logic [3:0]    def_prio_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] a1_r, a2_r, best_r, rmw_addr_r;
  logic          v1_r, v2_r, have_r, run_ok_r;
  logic [35:0]   cost_r, best_cost_r;
  logic [3:0]    res_old_r;
  logic [31:0]   res_sleep_r, res_ready_r, res_run_r;
  logic          slot_ok;
  logic [IW-1:0] slot_addr;
  logic          is_tick, is_pick;

  assign slot_ok   = 32'(slot_r) < SLOTS;
  assign slot_addr = IW'(slot_r);
  assign is_tick   = cmd_r == CMD_TICK;
  assign is_pick   = cmd_r == CMD_PICK;
  assign rd_row    = row_t'(rd_data_r);

  assign st.idx_last = idx_r == IW'(SLOTS - 1);
  assign st.is_scan  = is_tick || is_pick;
  assign st.is_pick  = is_pick;
  assign st.is_rmw   = cmd_r == CMD_SET_STATE || cmd_r == CMD_SET_PRIO || cmd_r == CMD_READ;
  assign st.have     = have_r;

  // Memory access: one read and one write per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_row;
    if (mem_re) rd_data_r <= mem[rd_addr];
  end

  assign mem_re  = cmd.scan_step || cmd.rmw_rd;
  assign rd_addr = cmd.scan_step ? idx_r : (is_pick ? best_r : slot_addr);

  // Write port: clearing pass, tick write-back, or single-slot update.
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = rmw_addr_r;
    wr_row  = rd_row;
    if (cmd.clear_step) begin
      mem_we  = 1'b1;
      wr_addr = idx_r;
      wr_row  = '0;
    end else if (v1_r && is_tick) begin
      mem_we  = 1'b1;
      wr_addr = a1_r;
      case (rd_row.status)
        PS_SLEEPING: if (rd_row.sleep_cnt != CNT_MAX) wr_row.sleep_cnt = rd_row.sleep_cnt + 32'd1;
        PS_RUNNABLE: if (rd_row.ready_cnt != CNT_MAX) wr_row.ready_cnt = rd_row.ready_cnt + 32'd1;
        PS_RUNNING:  if (rd_row.run_cnt != CNT_MAX)   wr_row.run_cnt   = rd_row.run_cnt + 32'd1;
        default: ;
      endcase
    end else if (cmd.rmw_wr) begin
      case (cmd_r)
        CMD_SET_STATE: begin
          if (slot_ok && nst_r <= PS_ZOMBIE) begin
            mem_we        = 1'b1;
            wr_row.status = nst_r;
            if (nst_r == PS_UNUSED || nst_r == PS_EMBRYO) begin
              wr_row.sleep_cnt = '0;
              wr_row.ready_cnt = '0;
              wr_row.run_cnt   = '0;
            end
            if (nst_r == PS_EMBRYO) wr_row.weight = def_prio_r;
          end
        end
        CMD_SET_PRIO: begin
          if (slot_ok) begin
            mem_we        = 1'b1;
            wr_row.weight = npri_r;
          end
        end
        CMD_PICK: begin
          mem_we        = 1'b1;
          wr_row.status = PS_RUNNING;
        end
        default: ;
      endcase
    end
  end

  // Control registers: configuration, slot index, scan pipeline valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_prio_r <= DEF_PRIO_RST;
      idx_r      <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      have_r     <= 1'b0;
      cmd_r      <= '0;
    end else begin
      if (cfg_wr_en) def_prio_r <= cfg_wr_data;
      if (cmd.clear_step || cmd.scan_step) begin
        idx_r <= st.idx_last ? '0 : idx_r + IW'(1);
      end
      v1_r <= cmd.scan_step;
      v2_r <= v1_r && is_pick;
      if (cmd.load) begin
        cmd_r  <= in_command;
        have_r <= 1'b0;
      end else if (v2_r && run_ok_r && (!have_r || cost_r < best_cost_r)) begin
        have_r <= 1'b1;
      end
    end
  end

  // Request capture, cost pipeline and per-request results.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_r      <= in_slot;
      nst_r       <= in_new_state;
      npri_r      <= in_new_priority;
      res_old_r   <= '0;
      res_sleep_r <= '0;
      res_ready_r <= '0;
      res_run_r   <= '0;
    end
    a1_r     <= idx_r;
    a2_r     <= a1_r;
    cost_r   <= 36'(rd_row.run_cnt) * 36'(rd_row.weight);
    run_ok_r <= rd_row.status == PS_RUNNABLE;
    if (v2_r && run_ok_r && (!have_r || cost_r < best_cost_r)) begin
      best_r      <= a2_r;
      best_cost_r <= cost_r;
    end
    if (cmd.rmw_rd) rmw_addr_r <= rd_addr;
    if (cmd.rmw_wr && slot_ok) begin
      if (cmd_r == CMD_SET_PRIO) res_old_r <= rd_row.weight;
      if (cmd_r == CMD_READ) begin
        res_sleep_r <= rd_row.sleep_cnt;
        res_ready_r <= rd_row.ready_cnt;
        res_run_r   <= rd_row.run_cnt;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found        <= is_pick ? have_r : 1'b1;
      out_chosen_slot  <= (is_pick && have_r) ? 6'(best_r) : 6'd0;
      out_old_priority <= res_old_r;
      out_sleep_ticks  <= res_sleep_r;
      out_ready_ticks  <= res_ready_r;
      out_run_ticks    <= res_run_r;
    end
  end

endmodule

@@ rtl/core/weighted_runtime_process_picker.sv @@
// Weighted-runtime process picker, top level. Depends on wrpp_pkg, wrpp_ctrl and wrpp_dpath.
// Tick and pick requests walk all slots one per cycle over the slot table, which has one read
// port and one write port; set state, set priority and read visit a single slot, and unknown
// commands go straight to the result. The next request is taken in the cycle after the result is
// loaded, so requests are handled one at a time; a stalled result holds off the next request.
// After reset a clearing pass zeroes the table; no request is taken until then.
module weighted_runtime_process_picker #(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [5:0]  in_slot,
  input  logic [2:0]  in_new_state,
  input  logic [3:0]  in_new_priority,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [5:0]  out_chosen_slot,
  output logic [3:0]  out_old_priority,
  output logic [31:0] out_sleep_ticks,
  output logic [31:0] out_ready_ticks,
  output logic [31:0] out_run_ticks,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);
  import wrpp_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t st;

  // Sequencing.
  wrpp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st)
  );

  // Slot table and arithmetic.
  wrpp_dpath #(.SLOTS(SLOTS)) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_command       (in_command),
    .in_slot          (in_slot),
    .in_new_state     (in_new_state),
    .in_new_priority  (in_new_priority),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_found        (out_found),
    .out_chosen_slot  (out_chosen_slot),
    .out_old_priority (out_old_priority),
    .out_sleep_ticks  (out_sleep_ticks),
    .out_ready_ticks  (out_ready_ticks),
    .out_run_ticks    (out_run_ticks)
  );

endmodule
